// File: rtl/lbpg_pkg.sv
// ----------------------------------------------------------------------------
// lbpg_pkg: shared types and constants of the load-based p-state governor
// Holds the per-CPU record layout, register indexes, reset values and the
// structs that pass between the control path and the decision logic.
// ----------------------------------------------------------------------------
package lbpg_pkg;

   localparam int CPU_INDEX_W = 4;
   localparam int CPU_SLOTS   = 2 ** CPU_INDEX_W;
   localparam int TIME_W      = 64;
   localparam int PSTATE_W    = 3;
   localparam int LOW_W       = 32;
   localparam int FAST_W      = 5;
   localparam int DELAY_W     = 16;
   localparam int GAIN_W      = 8;
   localparam int PROD_W      = FAST_W + GAIN_W;
   localparam int BOUND_W     = ((DELAY_W > PROD_W) ? DELAY_W : PROD_W) + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_UP_BUSY    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_DOWN_BUSY  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATE_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_DOWN_DELAY = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MULTI_CPU_GAIN  = 3'd5;

   // Register reset values.
   localparam logic [TIME_W-1:0]   RST_WINDOW_LENGTH   = 64'd100000000;
   localparam logic [TIME_W-1:0]   RST_STEP_UP_BUSY    = 64'd70000000;
   localparam logic [TIME_W-1:0]   RST_STEP_DOWN_BUSY  = 64'd30000000;
   localparam logic [PSTATE_W-1:0] RST_STATE_LIMIT     = 3'd2;
   localparam logic [DELAY_W-1:0]  RST_STEP_DOWN_DELAY = 16'd4;
   localparam logic [GAIN_W-1:0]   RST_MULTI_CPU_GAIN  = 8'd1;

   localparam logic [0:0] FUNC_IDLE_EXIT = 1'b0;
   localparam logic [0:0] FUNC_RESET_CPU = 1'b1;

   localparam logic [LOW_W-1:0] LOW_MAX = '1;

   typedef struct packed {
      logic [TIME_W-1:0]   total_accum;
      logic [TIME_W-1:0]   idle_accum;
      logic [TIME_W-1:0]   last_start;
      logic [LOW_W-1:0]    low_load_count;
      logic [PSTATE_W-1:0] cpu_state;
   } lbpg_rec_type;

   localparam int REC_W = $bits(lbpg_rec_type);

   // Everything the decision stage needs about one request.
   typedef struct packed {
      logic                func;
      logic                in_range;
      logic                window_done;
      logic [TIME_W-1:0]   busy_ticks;
      logic [BOUND_W-1:0]  bound;
      logic [TIME_W-1:0]   total_sum;
      logic [TIME_W-1:0]   idle_sum;
      logic [TIME_W-1:0]   wake_time;
      logic                counted;
      logic [FAST_W-1:0]   fast_count;
      lbpg_rec_type        rec;
   } lbpg_eval_type;

   typedef struct packed {
      logic                state_write;
      logic                counted;
      logic [FAST_W-1:0]   fast_count;
      lbpg_rec_type        rec;
   } lbpg_decision_type;

endpackage

// File: rtl/lbpg_ram.sv
// ----------------------------------------------------------------------------
// lbpg_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lbpg_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lbpg_decide.sv
// ----------------------------------------------------------------------------
// lbpg_decide: load decision and state request for one CPU record
// Compares the window's busy time with the thresholds, updates the low-load
// count, clamps the requested state and keeps the fast-CPU count in step.
// ----------------------------------------------------------------------------
module lbpg_decide (
   input  lbpg_pkg::lbpg_eval_type              ev,
   input  logic [lbpg_pkg::TIME_W-1:0]          step_up_busy,
   input  logic [lbpg_pkg::TIME_W-1:0]          step_down_busy,
   input  logic [lbpg_pkg::PSTATE_W-1:0]        state_limit,
   output lbpg_pkg::lbpg_decision_type          dec
);
   import lbpg_pkg::*;

   logic                  want_valid;
   logic [PSTATE_W:0]     want;
   logic [PSTATE_W:0]     clamped;
   logic [LOW_W-1:0]      low_inc;
   logic [PSTATE_W-1:0]   cur;

   always_comb begin
      dec        = '0;
      dec.rec    = ev.rec;
      dec.counted    = ev.counted;
      dec.fast_count = ev.fast_count;
      cur        = ev.rec.cpu_state;
      want_valid = 1'b0;
      want       = '0;
      clamped    = '0;
      low_inc    = (ev.rec.low_load_count == LOW_MAX) ? ev.rec.low_load_count
                                                      : ev.rec.low_load_count + 1'b1;

      if (ev.in_range) begin
         if (ev.func == FUNC_RESET_CPU) begin
            if (state_limit != '0) begin
               dec.rec.cpu_state = '0;
               dec.state_write   = 1'b1;
               if (!ev.counted) begin
                  dec.counted    = 1'b1;
                  dec.fast_count = ev.fast_count + 1'b1;
               end
            end
         end else begin
            dec.rec.total_accum = ev.total_sum;
            dec.rec.idle_accum  = ev.idle_sum;
            dec.rec.last_start  = ev.wake_time;
            if (ev.window_done) begin
               if (ev.busy_ticks > step_up_busy) begin
                  want_valid = 1'b1;
                  want       = (cur != '0) ? {1'b0, cur - 1'b1} : '0;
                  dec.rec.low_load_count = '0;
               end else if (ev.busy_ticks < step_down_busy) begin
                  if (low_inc > LOW_W'(ev.bound)) begin
                     dec.rec.low_load_count = '0;
                     want_valid = 1'b1;
                     want       = {1'b0, cur} + 1'b1;
                  end else begin
                     dec.rec.low_load_count = low_inc;
                  end
               end
               dec.rec.total_accum = '0;
               dec.rec.idle_accum  = '0;
            end

            // Clamp to the limit; only an actual change is written.
            clamped = (want > {1'b0, state_limit}) ? {1'b0, state_limit} : want;
            if (want_valid && state_limit != '0 && clamped[PSTATE_W-1:0] != cur) begin
               dec.rec.cpu_state = clamped[PSTATE_W-1:0];
               dec.state_write   = 1'b1;
               if (clamped == '0) begin
                  if (!ev.counted) begin
                     dec.counted    = 1'b1;
                     dec.fast_count = ev.fast_count + 1'b1;
                  end
               end else if (ev.counted) begin
                  dec.counted = 1'b0;
                  if (ev.fast_count != '0) begin
                     dec.fast_count = ev.fast_count - 1'b1;
                  end
               end
            end
         end
      end
   end

endmodule

// File: rtl/load_based_pstate_governor_unit.sv
// ----------------------------------------------------------------------------
// load_based_pstate_governor_unit: per-CPU load-threshold p-state governor
// Accumulates total and idle time per CPU in a record memory and, once a
// window closes, steps the CPU's performance state faster or slower.
//
//   channel   ports                           handshake
//   request   req_*                           start high while busy low
//   response  rsp_*                           rsp_valid for one cycle
//   config    csr_write_en, csr_index, csr_*  write enable, no wait
//
// Each request runs through a record read, the accumulator add, the window
// compare with busy subtract, and the decision with record write-back, in
// that order; busy is high in the read, evaluate and decide states. Reset
// clears the entry valid bits, so every CPU reads as zero at once with no
// clearing pass. The receiver cannot stall: rsp_valid lasts exactly one
// cycle.
// ----------------------------------------------------------------------------
module load_based_pstate_governor_unit #(
   parameter int NUM_CPUS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_func,
   input  logic [lbpg_pkg::CPU_INDEX_W-1:0]      req_cpu_index,
   input  logic [lbpg_pkg::TIME_W-1:0]           req_idle_start_time,
   input  logic [lbpg_pkg::TIME_W-1:0]           req_wake_time,
   output logic                                  rsp_valid,
   output logic                                  rsp_state_write,
   output logic [lbpg_pkg::PSTATE_W-1:0]         rsp_new_state,
   output logic [lbpg_pkg::FAST_W-1:0]           rsp_fast_cpu_count,
   output logic                                  rsp_window_done,
   output logic [lbpg_pkg::TIME_W-1:0]           rsp_busy_ticks,
   input  logic                                  csr_write_en,
   input  logic [lbpg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lbpg_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lbpg_pkg::*;

   localparam int CPU_DEPTH = (NUM_CPUS < CPU_SLOTS) ? NUM_CPUS : CPU_SLOTS;
   localparam int ADDR_W    = (CPU_DEPTH > 1) ? $clog2(CPU_DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_DECIDE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [TIME_W-1:0]   window_length_ff;
   logic [TIME_W-1:0]   step_up_busy_ff;
   logic [TIME_W-1:0]   step_down_busy_ff;
   logic [PSTATE_W-1:0] state_limit_ff;
   logic [DELAY_W-1:0]  step_down_delay_ff;
   logic [GAIN_W-1:0]   multi_cpu_gain_ff;

   // Per-CPU flags kept in flops so that reset takes effect at once.
   logic [CPU_DEPTH-1:0] valid_ff, valid_in;
   logic [CPU_DEPTH-1:0] counted_ff, counted_in;
   logic [FAST_W-1:0]    fast_ff, fast_in;

   // Request payload and stage registers.
   logic                func_ff;
   logic                in_range_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [TIME_W-1:0]   wake_ff;
   logic [TIME_W-1:0]   idle_delta_ff;
   lbpg_rec_type        rec_ff, rec_in;
   logic [TIME_W-1:0]   total_sum_ff, total_sum_in;
   logic [TIME_W-1:0]   idle_sum_ff, idle_sum_in;
   logic                done_ff, done_in;
   logic [TIME_W-1:0]   busy_ticks_ff, busy_ticks_in;
   logic [BOUND_W-1:0]  bound_ff, bound_in;
   logic [PROD_W-1:0]   gain_prod;

   // Response registers.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_state_write_ff, rsp_state_write_in;
   logic [PSTATE_W-1:0] rsp_new_state_ff, rsp_new_state_in;
   logic [FAST_W-1:0]   rsp_fast_ff, rsp_fast_in;
   logic                rsp_done_ff, rsp_done_in;
   logic [TIME_W-1:0]   rsp_busy_ff, rsp_busy_in;

   logic                accept;
   logic                req_in_range;
   logic [REC_W-1:0]    rd_data;
   lbpg_rec_type        rd_rec;
   logic                wr_en;
   lbpg_eval_type       ev;
   lbpg_decision_type   dec;

   assign busy         = (state_ff != S_IDLE);
   assign accept       = start && !busy;
   assign req_in_range = (32'(req_cpu_index) < NUM_CPUS);
   assign wr_en        = (state_ff == S_DECIDE) && in_range_ff;

   lbpg_ram #(
      .WIDTH (REC_W),
      .DEPTH (CPU_DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (dec.rec),
      .rd_en   (accept),
      .rd_addr (req_cpu_index[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // An entry never written since reset reads as all zero.
   assign rd_rec = valid_ff[addr_ff] ? lbpg_rec_type'(rd_data) : '0;

   always_comb begin
      ev             = '0;
      ev.func        = func_ff;
      ev.in_range    = in_range_ff;
      ev.window_done = done_ff;
      ev.busy_ticks  = busy_ticks_ff;
      ev.bound       = bound_ff;
      ev.total_sum   = total_sum_ff;
      ev.idle_sum    = idle_sum_ff;
      ev.wake_time   = wake_ff;
      ev.counted     = counted_ff[addr_ff];
      ev.fast_count  = fast_ff;
      ev.rec         = rec_ff;
   end

   lbpg_decide u_decide (
      .ev             (ev),
      .step_up_busy   (step_up_busy_ff),
      .step_down_busy (step_down_busy_ff),
      .state_limit    (state_limit_ff),
      .dec            (dec)
   );

   assign gain_prod = fast_ff * multi_cpu_gain_ff;

   always_comb begin
      state_in           = state_ff;
      valid_in           = valid_ff;
      counted_in         = counted_ff;
      fast_in            = fast_ff;
      rec_in             = rec_ff;
      total_sum_in       = total_sum_ff;
      idle_sum_in        = idle_sum_ff;
      done_in            = done_ff;
      busy_ticks_in      = busy_ticks_ff;
      bound_in           = bound_ff;
      rsp_valid_in       = 1'b0;
      rsp_state_write_in = rsp_state_write_ff;
      rsp_new_state_in   = rsp_new_state_ff;
      rsp_fast_in        = rsp_fast_ff;
      rsp_done_in        = rsp_done_ff;
      rsp_busy_in        = rsp_busy_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            rec_in       = rd_rec;
            total_sum_in = rd_rec.total_accum + (wake_ff - rd_rec.last_start);
            idle_sum_in  = rd_rec.idle_accum + idle_delta_ff;
            state_in     = S_EVAL;
         end
         S_EVAL: begin
            done_in       = (func_ff == FUNC_IDLE_EXIT) && in_range_ff
                            && (total_sum_ff > window_length_ff);
            busy_ticks_in = total_sum_ff - idle_sum_ff;
            bound_in      = BOUND_W'(step_down_delay_ff) + BOUND_W'(gain_prod);
            state_in      = S_DECIDE;
         end
         S_DECIDE: begin
            if (in_range_ff) begin
               valid_in[addr_ff]   = 1'b1;
               counted_in[addr_ff] = dec.counted;
               fast_in             = dec.fast_count;
            end
            rsp_valid_in       = 1'b1;
            rsp_state_write_in = in_range_ff && dec.state_write;
            rsp_new_state_in   = in_range_ff ? dec.rec.cpu_state : '0;
            rsp_fast_in        = in_range_ff ? dec.fast_count : fast_ff;
            rsp_done_in        = done_ff;
            rsp_busy_in        = done_ff ? busy_ticks_ff : '0;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state, configuration and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         valid_ff           <= '0;
         counted_ff         <= '0;
         fast_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
         rsp_state_write_ff <= 1'b0;
         rsp_new_state_ff   <= '0;
         rsp_fast_ff        <= '0;
         rsp_done_ff        <= 1'b0;
         rsp_busy_ff        <= '0;
         window_length_ff   <= RST_WINDOW_LENGTH;
         step_up_busy_ff    <= RST_STEP_UP_BUSY;
         step_down_busy_ff  <= RST_STEP_DOWN_BUSY;
         state_limit_ff     <= RST_STATE_LIMIT;
         step_down_delay_ff <= RST_STEP_DOWN_DELAY;
         multi_cpu_gain_ff  <= RST_MULTI_CPU_GAIN;
      end else begin
         state_ff           <= state_in;
         valid_ff           <= valid_in;
         counted_ff         <= counted_in;
         fast_ff            <= fast_in;
         rsp_valid_ff       <= rsp_valid_in;
         rsp_state_write_ff <= rsp_state_write_in;
         rsp_new_state_ff   <= rsp_new_state_in;
         rsp_fast_ff        <= rsp_fast_in;
         rsp_done_ff        <= rsp_done_in;
         rsp_busy_ff        <= rsp_busy_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_WINDOW_LENGTH:   window_length_ff   <= csr_wdata;
               CSR_STEP_UP_BUSY:    step_up_busy_ff    <= csr_wdata;
               CSR_STEP_DOWN_BUSY:  step_down_busy_ff  <= csr_wdata;
               CSR_STATE_LIMIT:     state_limit_ff     <= csr_wdata[PSTATE_W-1:0];
               CSR_STEP_DOWN_DELAY: step_down_delay_ff <= csr_wdata[DELAY_W-1:0];
               CSR_MULTI_CPU_GAIN:  multi_cpu_gain_ff  <= csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff       <= req_func;
         in_range_ff   <= req_in_range;
         addr_ff       <= req_cpu_index[ADDR_W-1:0];
         wake_ff       <= req_wake_time;
         idle_delta_ff <= req_wake_time - req_idle_start_time;
      end
      rec_ff        <= rec_in;
      total_sum_ff  <= total_sum_in;
      idle_sum_ff   <= idle_sum_in;
      done_ff       <= done_in;
      busy_ticks_ff <= busy_ticks_in;
      bound_ff      <= bound_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_state_write    = rsp_state_write_ff;
   assign rsp_new_state      = rsp_new_state_ff;
   assign rsp_fast_cpu_count = rsp_fast_ff;
   assign rsp_window_done    = rsp_done_ff;
   assign rsp_busy_ticks     = rsp_busy_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for load_based_pstate_governor_unit
// A short table of directed requests is followed by random requests under
// eight register settings. Every accepted request is run through a local
// model, and each response is compared field by field with it, or with the row's typed-in result.
// ----------------------------------------------------------------------------
module testbench;
   import lbpg_pkg::*;

   localparam int NUM_CPUS           = 16;
   localparam int DIRECTED_ROWS      = 20;
   localparam int PHASES             = 8;
   localparam int REQUESTS_PER_PHASE = 92;
   localparam int QUIET_LIMIT        = 1000;
   localparam int DRAIN_CYCLES       = 8;
   localparam int HEAVY_PERCENT      = 40;
   localparam logic [TIME_W-1:0] TICKS_MAX = '1;

   typedef struct packed {
      logic                state_write;
      logic [PSTATE_W-1:0] new_state;
      logic [FAST_W-1:0]   fast_cpu_count;
      logic                window_done;
      logic [TIME_W-1:0]   busy_ticks;
   } gov_result_type;

   typedef struct {
      logic                   func;
      logic [CPU_INDEX_W-1:0] cpu;
      logic [TIME_W-1:0]      idle_start;
      logic [TIME_W-1:0]      wake;
      bit                     known;
      gov_result_type         result;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_func;
   logic [CPU_INDEX_W-1:0] req_cpu_index;
   logic [TIME_W-1:0]      req_idle_start_time;
   logic [TIME_W-1:0]      req_wake_time;
   logic                   rsp_valid;
   logic                   rsp_state_write;
   logic [PSTATE_W-1:0]    rsp_new_state;
   logic [FAST_W-1:0]      rsp_fast_cpu_count;
   logic                   rsp_window_done;
   logic [TIME_W-1:0]      rsp_busy_ticks;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Expectation attached to the request currently on the bus, if typed in.
   bit             row_known;
   gov_result_type row_result;

   // Local copy of the governor state and its registers.
   logic [PSTATE_W-1:0] pstate      [CPU_SLOTS];
   logic [TIME_W-1:0]   total_ticks [CPU_SLOTS];
   logic [TIME_W-1:0]   idle_ticks  [CPU_SLOTS];
   logic [TIME_W-1:0]   last_wake   [CPU_SLOTS];
   logic [LOW_W-1:0]    low_windows [CPU_SLOTS];
   bit                  fast_member [CPU_SLOTS];
   int unsigned         fast_cpus;
   logic [TIME_W-1:0]   win_len;
   logic [TIME_W-1:0]   up_busy;
   logic [TIME_W-1:0]   down_busy;
   logic [PSTATE_W-1:0] limit_cfg;
   logic [DELAY_W-1:0]  delay_cfg;
   logic [GAIN_W-1:0]   gain_cfg;

   gov_result_type expected_results [$];
   int             failures;
   int             quiet_cycles;
   int             requests_accepted;
   int             windows_closed;
   int             state_writes;

   load_based_pstate_governor_unit #(
      .NUM_CPUS (NUM_CPUS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_cpu_index       (req_cpu_index),
      .req_idle_start_time (req_idle_start_time),
      .req_wake_time       (req_wake_time),
      .rsp_valid           (rsp_valid),
      .rsp_state_write     (rsp_state_write),
      .rsp_new_state       (rsp_new_state),
      .rsp_fast_cpu_count  (rsp_fast_cpu_count),
      .rsp_window_done     (rsp_window_done),
      .rsp_busy_ticks      (rsp_busy_ticks),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [TIME_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Moves a CPU towards the wanted state, clamped to the limit, and keeps
   // the count of CPUs in the fastest state. Returns 1 if a write happened.
   function automatic bit move_state(input int unsigned c, input int unsigned want);
      if (limit_cfg == 0) return 1'b0;
      if (want > limit_cfg) want = limit_cfg;
      if (want == pstate[c]) return 1'b0;
      pstate[c] = want[PSTATE_W-1:0];
      if (want == 0) begin
         if (!fast_member[c]) begin
            fast_member[c] = 1'b1;
            fast_cpus++;
         end
      end else if (fast_member[c]) begin
         fast_member[c] = 1'b0;
         if (fast_cpus > 0) fast_cpus--;
      end
      return 1'b1;
   endfunction

   function automatic gov_result_type govern(input logic func,
                                             input logic [CPU_INDEX_W-1:0] cpu,
                                             input logic [TIME_W-1:0] idle_start,
                                             input logic [TIME_W-1:0] wake);
      gov_result_type    r;
      logic [TIME_W-1:0] bound;
      r = '0;
      if (cpu < NUM_CPUS) begin
         if (func == FUNC_RESET_CPU) begin
            if (limit_cfg != 0) begin
               pstate[cpu] = '0;
               if (!fast_member[cpu]) begin
                  fast_member[cpu] = 1'b1;
                  fast_cpus++;
               end
               r.state_write = 1'b1;
            end
         end else begin
            total_ticks[cpu] += wake - last_wake[cpu];
            idle_ticks[cpu]  += wake - idle_start;
            if (total_ticks[cpu] > win_len) begin
               r.window_done = 1'b1;
               r.busy_ticks  = total_ticks[cpu] - idle_ticks[cpu];
               if (r.busy_ticks > up_busy) begin
                  r.state_write = move_state(cpu, (pstate[cpu] > 0) ? int'(pstate[cpu]) - 1 : 0);
                  low_windows[cpu] = '0;
               end else if (r.busy_ticks < down_busy) begin
                  if (low_windows[cpu] != LOW_MAX) low_windows[cpu]++;
                  bound = 64'(delay_cfg) + 64'(fast_cpus) * 64'(gain_cfg);
                  // The low-load count clears even when the limit blocks the step.
                  if (64'(low_windows[cpu]) > bound) begin
                     low_windows[cpu] = '0;
                     r.state_write = move_state(cpu, int'(pstate[cpu]) + 1);
                  end
               end
               total_ticks[cpu] = '0;
               idle_ticks[cpu]  = '0;
            end
            last_wake[cpu] = wake;
         end
         r.new_state = pstate[cpu];
      end
      r.fast_cpu_count = fast_cpus[FAST_W-1:0];
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                       input logic [TIME_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   // Both the request and the response side are sampled here at the rising edge.
   always @(posedge clock) begin : monitor
      bit             accepted;
      gov_result_type want;
      gov_result_type predicted;
      if (!reset) begin
         accepted = start && !busy;
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("response seen with no request outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("state_write", 64'(want.state_write), 64'(rsp_state_write));
               check_field("new_state", 64'(want.new_state), 64'(rsp_new_state));
               check_field("fast_cpu_count", 64'(want.fast_cpu_count),
                           64'(rsp_fast_cpu_count));
               check_field("window_done", 64'(want.window_done), 64'(rsp_window_done));
               check_field("busy_ticks", want.busy_ticks, rsp_busy_ticks);
               windows_closed += rsp_window_done;
               state_writes   += rsp_state_write;
            end
         end
         if (accepted) begin
            predicted = govern(req_func, req_cpu_index, req_idle_start_time, req_wake_time);
            expected_results.push_back(row_known ? row_result : predicted);
            requests_accepted++;
         end
         quiet_cycles = (accepted || rsp_valid) ? 0 : quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      do @(negedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   // with start still high.
   task automatic issue(input logic func, input logic [CPU_INDEX_W-1:0] cpu,
                        input logic [TIME_W-1:0] idle_start, input logic [TIME_W-1:0] wake,
                        input bit known, input gov_result_type result);
      start               <= 1'b1;
      req_func            <= func;
      req_cpu_index       <= cpu;
      req_idle_start_time <= idle_start;
      req_wake_time       <= wake;
      row_known           <= known;
      row_result          <= result;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic maybe_pause(input bit steady);
      if (!steady && $urandom_range(0, 99) < 24) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      case (index)
         CSR_WINDOW_LENGTH:   win_len   = data;
         CSR_STEP_UP_BUSY:    up_busy   = data;
         CSR_STEP_DOWN_BUSY:  down_busy = data;
         CSR_STATE_LIMIT:     limit_cfg = data[PSTATE_W-1:0];
         CSR_STEP_DOWN_DELAY: delay_cfg = data[DELAY_W-1:0];
         CSR_MULTI_CPU_GAIN:  gain_cfg  = data[GAIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   initial begin : stimulus
      directed_row_type       rows [DIRECTED_ROWS];
      logic [TIME_W-1:0]      cfg_win, cfg_up, cfg_down, span, delta, slack, wake;
      logic [PSTATE_W-1:0]    cfg_lim;
      logic [DELAY_W-1:0]     cfg_dly;
      logic [GAIN_W-1:0]      cfg_gain;
      logic [CPU_INDEX_W-1:0] cpu;
      int                     roll;

      reset               <= 1'b1;
      start               <= 1'b0;
      req_func            <= FUNC_IDLE_EXIT;
      req_cpu_index       <= '0;
      req_idle_start_time <= '0;
      req_wake_time       <= '0;
      csr_write_en        <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      row_known           <= 1'b0;
      row_result          <= '0;
      failures          = 0;
      quiet_cycles      = 0;
      requests_accepted = 0;
      windows_closed    = 0;
      state_writes      = 0;
      fast_cpus         = 0;
      win_len   = RST_WINDOW_LENGTH;
      up_busy   = RST_STEP_UP_BUSY;
      down_busy = RST_STEP_DOWN_BUSY;
      limit_cfg = RST_STATE_LIMIT;
      delay_cfg = RST_STEP_DOWN_DELAY;
      gain_cfg  = RST_MULTI_CPU_GAIN;
      for (int i = 0; i < CPU_SLOTS; i++) begin
         pstate[i]      = '0;
         total_ticks[i] = '0;
         idle_ticks[i]  = '0;
         last_wake[i]   = '0;
         low_windows[i] = '0;
         fast_member[i] = 1'b0;
      end

      // Reset values apply here. CPU 5 sees six quiet windows, which steps it
      // slower, then a busy one that brings it back; CPU 6 has wrapping times.
      rows = '{
         '{FUNC_RESET_CPU, 4'd0, 64'd0, 64'd0, 1'b1, '{1'b1, 3'd0, 5'd1, 1'b0, 64'd0}},
         '{FUNC_IDLE_EXIT, 4'd1, 64'd0, 64'd0, 1'b1, '{1'b0, 3'd0, 5'd1, 1'b0, 64'd0}},
         '{FUNC_IDLE_EXIT, 4'd2, 64'd0, TICKS_MAX, 1'b1, '{1'b0, 3'd0, 5'd1, 1'b1, 64'd0}},
         '{FUNC_IDLE_EXIT, 4'd3, TICKS_MAX, TICKS_MAX, 1'b1,
           '{1'b0, 3'd0, 5'd1, 1'b1, TICKS_MAX}},
         '{FUNC_IDLE_EXIT, 4'd4, 64'd100000000, 64'd100000000, 1'b1,
           '{1'b0, 3'd0, 5'd1, 1'b0, 64'd0}},
         '{FUNC_IDLE_EXIT, 4'd4, 64'd100000001, 64'd100000001, 1'b1,
           '{1'b0, 3'd0, 5'd1, 1'b1, 64'd100000001}},
         '{FUNC_IDLE_EXIT, 4'd5, 64'd0, 64'd200000000, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd5, 64'd200000000, 64'd400000000, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd5, 64'd400000000, 64'd600000000, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd5, 64'd600000000, 64'd800000000, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd5, 64'd800000000, 64'd1000000000, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd5, 64'd1000000000, 64'd1200000000, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd5, 64'd1400000000, 64'd1400000000, 1'b0, '0},
         '{FUNC_RESET_CPU, 4'd5, TICKS_MAX, TICKS_MAX, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd6, 64'hFFFF_FFFF_FFFF_FFF5, 64'd5, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd6, 64'd3, 64'd3, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd6, 64'd3, 64'd200000000, 1'b0, '0},
         '{FUNC_RESET_CPU, 4'd15, 64'd0, TICKS_MAX, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd10, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '0},
         '{FUNC_IDLE_EXIT, 4'd9, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         issue(rows[r].func, rows[r].cpu, rows[r].idle_start, rows[r].wake,
               rows[r].known, rows[r].result);
         maybe_pause(1'b0);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         span = 64'd600;
         case (phase)
            0: begin
               cfg_win = 64'd1000; cfg_up = 64'd700; cfg_down = 64'd300;
               cfg_lim = 3'd7; cfg_dly = 16'd0; cfg_gain = 8'd0;
            end
            1: begin
               // A lower limit clamps CPUs left in slow states.
               cfg_win = 64'd1000; cfg_up = 64'd600; cfg_down = 64'd400;
               cfg_lim = 3'd3; cfg_dly = 16'd2; cfg_gain = 8'd1;
            end
            2: begin
               cfg_win = 64'd500; cfg_up = 64'd250; cfg_down = 64'd0;
               cfg_lim = 3'd0; cfg_dly = 16'd0; cfg_gain = 8'd1; span = 64'd300;
            end
            3: begin
               cfg_win = TICKS_MAX; cfg_up = 64'd0; cfg_down = TICKS_MAX;
               cfg_lim = 3'd7; cfg_dly = 16'hFFFF; cfg_gain = 8'hFF; span = TICKS_MAX;
            end
            4: begin
               cfg_win = 64'd1; cfg_up = 64'd0; cfg_down = TICKS_MAX;
               cfg_lim = 3'd5; cfg_dly = 16'd0; cfg_gain = 8'd0; span = 64'd50;
            end
            5: begin
               cfg_win = 64'd2000; cfg_up = 64'd1500; cfg_down = 64'd800;
               cfg_lim = 3'd6; cfg_dly = 16'd1; cfg_gain = 8'hFF; span = 64'd900;
            end
            6: begin
               cfg_win = rand64() | 64'd1; cfg_up = rand64(); cfg_down = rand64();
               cfg_lim = 3'($urandom_range(0, 7)); cfg_dly = 16'($urandom_range(0, 65535));
               cfg_gain = 8'($urandom_range(0, 255)); span = rand64() | 64'd1;
            end
            default: begin
               // Every closed window counts as quiet, so CPUs walk to the slowest state.
               cfg_win = 64'd800; cfg_up = TICKS_MAX; cfg_down = TICKS_MAX;
               cfg_lim = 3'd7; cfg_dly = 16'd0; cfg_gain = 8'd0; span = 64'd500;
            end
         endcase
         drain();
         csr_write(CSR_WINDOW_LENGTH, cfg_win);
         csr_write(CSR_STEP_UP_BUSY, cfg_up);
         csr_write(CSR_STEP_DOWN_BUSY, cfg_down);
         csr_write(CSR_STATE_LIMIT, 64'(cfg_lim));
         csr_write(CSR_STEP_DOWN_DELAY, 64'(cfg_dly));
         csr_write(CSR_MULTI_CPU_GAIN, 64'(cfg_gain));
         csr_write_en <= 1'b0;

         for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               issue(FUNC_RESET_CPU, 4'($urandom_range(0, 15)), rand64(), rand64(), 1'b0, '0);
            end else if (roll < 20) begin
               issue(FUNC_IDLE_EXIT, 4'($urandom_range(0, 15)), rand64(), rand64(), 1'b0, '0);
            end else begin
               // Consistent wake sequences on a few CPUs, so windows keep closing.
               cpu   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 3));
               delta = rand64() % span + 64'd1;
               slack = rand64() % (delta / 8 + 64'd1);
               wake  = last_wake[cpu] + delta;
               if ($urandom_range(0, 99) < HEAVY_PERCENT)
                  issue(FUNC_IDLE_EXIT, cpu, wake - slack, wake, 1'b0, '0);
               else
                  issue(FUNC_IDLE_EXIT, cpu, wake - (delta - slack), wake, 1'b0, '0);
            end
            maybe_pause(phase == 5);
         end
      end

      drain();
      if (expected_results.size() != 0) begin
         $error("%0d responses never arrived", expected_results.size());
         failures++;
      end
      $display("%0d requests checked across %0d register settings", requests_accepted,
               PHASES + 1);
      $display("%0d evaluation windows closed, %0d state writes", windows_closed, state_writes);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
